FILE: hdl/stepper_angle_sequencer_defines.svh
// ----------------------------------------------------------------------------
// stepper angle sequencer assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef STEPPER_ANGLE_SEQUENCER_DEFINES_SVH
`define STEPPER_ANGLE_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SSQ_ASSERT_NOW(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SSQ_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hdl/ssq_pkg.sv
// ----------------------------------------------------------------------------
// ssq_pkg
// shared codes, constants, types and phase tables of the angle sequencer
// ----------------------------------------------------------------------------
package ssq_pkg;

  // action codes, code 3 is ignored
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_ABORT = 2'd2;

  typedef enum logic [2:0] {
    ST_RUNNING  = 3'd0,
    ST_DONE     = 3'd1,
    ST_IDLE     = 3'd2,
    ST_REJECTED = 3'd3,
    ST_ACCEPTED = 3'd4,
    ST_ABORTED  = 3'd5
  } ssq_status_e;

  localparam logic [3:0]  COIL_OFF     = 4'hF;
  localparam logic [6:0]  CHECK_PERIOD = 7'd84;
  localparam logic [11:0] SNAP_FROM    = 12'd2016;
  localparam logic [11:0] SNAP_TO      = 12'd2048;
  localparam logic [6:0]  SNAP_PHASE   = 7'(2048 % 84);
  localparam logic [11:0] STEP_INC     = 12'd4;
  localparam logic [8:0]  POS_INC      = 9'd15;
  localparam int          MAX_DEG      = 360;
  localparam logic [3:0]  BAR_LEVELS   = 4'd8;
  localparam logic [2:0]  FULL_LAST    = 3'd3;
  localparam logic [2:0]  HALF_LAST    = 3'd7;

  localparam logic [3:0] FULL_CW  [4] = '{4'h7, 4'hB, 4'hD, 4'hE};
  localparam logic [3:0] FULL_CCW [4] = '{4'hE, 4'hD, 4'hB, 4'h7};
  localparam logic [3:0] HALF_CW  [8] = '{4'h7, 4'h3, 4'hB, 4'h9, 4'hD, 4'hC, 4'hE, 4'h6};
  localparam logic [3:0] HALF_CCW [8] = '{4'hE, 4'hC, 4'hD, 4'h9, 4'hB, 4'h3, 4'h7, 4'h6};

  // template of one result burst, handed from control to the emitter
  typedef struct packed {
    logic        single;
    logic        mode;
    logic        dir;
    logic [7:0]  leds;
    logic [8:0]  pos;
    logic        upd;
    ssq_status_e status;
  } ssq_burst_t;

  // multiple of 15 no larger than 360
  function automatic logic valid_target(logic [9:0] deg);
    logic ok;
    ok = 1'b0;
    for (int i = 0; i <= MAX_DEG / 15; i++) begin
      if (deg == 10'(i * 15)) ok = 1'b1;
    end
    return ok;
  endfunction

  // n lit leds, from bit 7 down when ccw, from bit 0 up otherwise
  function automatic logic [7:0] bar_fill(logic [3:0] n, logic ccw);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (ccw) r[7 - i] = (4'(i) < n);
      else     r[i]     = (4'(i) < n);
    end
    return r;
  endfunction

  function automatic logic [3:0] coil_for(logic mode, logic dir, logic [2:0] k);
    logic [3:0] c;
    case ({mode, dir})
      2'b00:   c = FULL_CW[k[1:0]];
      2'b01:   c = FULL_CCW[k[1:0]];
      2'b10:   c = HALF_CW[k];
      default: c = HALF_CCW[k];
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/ssq_ctrl.sv
// ----------------------------------------------------------------------------
// ssq_ctrl
// move state and per-item decision, one item per cycle while items are taken
// ----------------------------------------------------------------------------
module ssq_ctrl import ssq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [1:0] action_i,
  input  logic [9:0] target_deg_i,
  input  logic       direction_i,
  input  logic       half_step_i,
  output ssq_burst_t burst_o
);

  logic        running_q, running_d;
  logic [11:0] cnt_q, cnt_d;
  logic [6:0]  ph_q, ph_d;
  logic [8:0]  pos_q, pos_d;
  logic [8:0]  target_q, target_d;
  logic        dir_q, dir_d;
  logic        mode_q, mode_d;
  logic [7:0]  leds_q, leds_d;

  logic        chk, snap, done;
  logic [11:0] cnt_a, cnt_inc;
  logic [6:0]  ph_a, ph_sum;

  always_comb begin
    chk     = (ph_q == '0);
    snap    = chk && (cnt_q == SNAP_FROM);
    cnt_a   = snap ? SNAP_TO : cnt_q;
    ph_a    = snap ? SNAP_PHASE : ph_q;
    cnt_inc = cnt_a + STEP_INC;
    ph_sum  = ph_a + STEP_INC[6:0];
    done    = chk && (pos_q == target_q);
  end

  always_comb begin
    running_d = running_q;
    cnt_d     = cnt_q;
    ph_d      = ph_q;
    pos_d     = pos_q;
    target_d  = target_q;
    dir_d     = dir_q;
    mode_d    = mode_q;
    leds_d    = leds_q;
    burst_o.single = 1'b1;
    burst_o.upd    = 1'b0;
    burst_o.status = running_q ? ST_RUNNING : ST_IDLE;
    case (action_i)
      ACT_START: begin
        if (valid_target(target_deg_i)) begin
          target_d  = target_deg_i[8:0];
          dir_d     = direction_i;
          mode_d    = half_step_i;
          cnt_d     = '0;
          ph_d      = '0;
          pos_d     = '0;
          leds_d    = '0;
          running_d = 1'b1;
          burst_o.status = ST_ACCEPTED;
        end else begin
          burst_o.status = ST_REJECTED;
        end
      end
      ACT_ABORT: begin
        running_d = 1'b0;
        cnt_d     = '0;
        ph_d      = '0;
        pos_d     = '0;
        leds_d    = '0;
        burst_o.status = ST_ABORTED;
      end
      ACT_TICK: begin
        if (running_q) begin
          burst_o.single = 1'b0;
          burst_o.upd    = chk && !done;
          burst_o.status = done ? ST_DONE : ST_RUNNING;
          if (chk) pos_d = pos_q + POS_INC;
          if (cnt_a[7:0] == '0 && cnt_a != '0 && cnt_a[11:8] <= BAR_LEVELS) begin
            leds_d = bar_fill(cnt_a[11:8], dir_q);
          end
          cnt_d = cnt_inc;
          if (cnt_inc == '0)              ph_d = '0;
          else if (ph_sum >= CHECK_PERIOD) ph_d = ph_sum - CHECK_PERIOD;
          else                            ph_d = ph_sum;
          if (done) begin
            running_d = 1'b0;
            cnt_d     = '0;
            ph_d      = '0;
            pos_d     = '0;
            leds_d    = '0;
          end
        end
      end
      default: ;
    endcase
    burst_o.mode = mode_d;
    burst_o.dir  = dir_d;
    burst_o.leds = leds_d;
    burst_o.pos  = pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      cnt_q     <= '0;
      ph_q      <= '0;
      pos_q     <= '0;
      target_q  <= '0;
      dir_q     <= 1'b0;
      mode_q    <= 1'b0;
      leds_q    <= '0;
    end else if (take_i) begin
      running_q <= running_d;
      cnt_q     <= cnt_d;
      ph_q      <= ph_d;
      pos_q     <= pos_d;
      target_q  <= target_d;
      dir_q     <= dir_d;
      mode_q    <= mode_d;
      leds_q    <= leds_d;
    end
  end

endmodule

FILE: hdl/ssq_emit.sv
// ----------------------------------------------------------------------------
// ssq_emit
// result register and coil phase sequencer, one result per cycle while tready is high
// ----------------------------------------------------------------------------
module ssq_emit import ssq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  ssq_burst_t  burst_i,
  output logic        free_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  logic       valid_q;
  logic [2:0] k_q;
  ssq_burst_t burst_q;
  logic       last;
  logic [3:0] coil;

  assign last   = burst_q.single || (k_q == (burst_q.mode ? HALF_LAST : FULL_LAST));
  assign coil   = burst_q.single ? COIL_OFF : coil_for(burst_q.mode, burst_q.dir, k_q);
  assign free_o = !valid_q || (m_axis_tready && last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      k_q     <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      k_q     <= '0;
    end else if (valid_q && m_axis_tready) begin
      if (last) valid_q <= 1'b0;
      else      k_q     <= k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) burst_q <= burst_i;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {2'b0, burst_q.upd, burst_q.pos, burst_q.leds, coil};
  assign m_axis_tuser  = burst_q.status;
  assign m_axis_tlast  = last;

endmodule

FILE: hdl/stepper_angle_sequencer.sv
// ----------------------------------------------------------------------------
// stepper_angle_sequencer
// full-step / half-step coil sequencer with angle tracking and led bar
// ----------------------------------------------------------------------------
// usage
//   input stream: one item per command; tuser carries the action (start, tick,
//   abort), tdata the target angle, direction and step mode for a start
//   output stream: coil pattern, led bar, reported angle and update flag in
//   tdata, status in tuser, tlast on the final result of each input item
//   a start, an abort, an idle tick or an unused action give one result with
//   all coils off; a tick while running gives 4 (full step) or 8 (half step)
//   results, one coil phase each
//   first result: valid in the cycle after the input item is taken
//   the phase sequencer drives one result per cycle out of the result
//   register while tready is high; the next item is taken in the cycle
//   its last result goes
//   reset: idle, position, count, target and leds cleared, no result pending
//   stall: while the receiver holds tready low the current result stays put
//   and s_axis_tready stays low until the last result of the burst is taken
// ----------------------------------------------------------------------------
module stepper_angle_sequencer import ssq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // target_deg[9:0], direction[10], half_step[11]
  input  logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // coil[3:0], led_bar[11:4], position_deg[20:12],
                                     // position_update[21]
  output logic [2:0]  m_axis_tuser,  // status[2:0]
  output logic        m_axis_tlast
);

  logic       free;
  logic       take;
  ssq_burst_t burst;

  // an item goes in whenever the result register is empty or draining its last
  assign s_axis_tready = free;
  assign take          = s_axis_tvalid && free;

  // move state, decides the whole burst for one item
  ssq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .action_i     (s_axis_tuser),
    .target_deg_i (s_axis_tdata[9:0]),
    .direction_i  (s_axis_tdata[10]),
    .half_step_i  (s_axis_tdata[11]),
    .burst_o      (burst)
  );

  // result register, steps through the coil phases of the burst
  ssq_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take),
    .burst_i       (burst),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: hdl/ssq_checker.sv
// ----------------------------------------------------------------------------
// ssq_checker
// port-level checks of the angle sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "stepper_angle_sequencer_defines.svh"

module ssq_checker import ssq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  logic single_kind;

  // these statuses only come from items with a single result
  assign single_kind = (m_axis_tuser == ST_IDLE) || (m_axis_tuser == ST_REJECTED) ||
                       (m_axis_tuser == ST_ACCEPTED) || (m_axis_tuser == ST_ABORTED);

  `SSQ_ASSERT_NOW(a_single_off, clk_i, rst_ni, m_axis_tvalid && single_kind,
    m_axis_tdata[3:0] == COIL_OFF, "command result drives a coil")
  `SSQ_ASSERT_NOW(a_done_clear, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == ST_DONE,
    m_axis_tdata[20:4] == '0, "finished move keeps position or leds")
  `SSQ_ASSERT_NOW(a_pos_range, clk_i, rst_ni, m_axis_tvalid,
    m_axis_tdata[20:12] <= 9'(MAX_DEG), "reported angle beyond full turn")
  `SSQ_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `SSQ_ASSERT_NOW(a_no_take_stalled, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    !s_axis_tready, "item taken while result stalled")

endmodule

bind stepper_angle_sequencer ssq_checker u_ssq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: bench/stepper_angle_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_angle_sequencer_test
// self-checking bench: directed table then random moves, each result checked
// against an in-bench model of the phase sequencer, with random idling
// ----------------------------------------------------------------------------
module stepper_angle_sequencer_test;
  import ssq_pkg::*;

  // unused action code, answered with a single status item
  localparam logic [1:0] ACT_NONE = 2'd3;
  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  localparam int N_DIRECTED = 24;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [3:0]  coil;
    logic [7:0]  leds;
    logic [8:0]  pos;
    logic        upd;
    ssq_status_e status;
    logic        last;
  } phase_result_t;

  // one directed row; typed rows carry the status read straight off the spec
  typedef struct packed {
    logic [1:0]  act;
    logic [9:0]  deg;
    logic        dir;
    logic        half;
    logic        typed;
    ssq_status_e status;
  } stim_row_t;

  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ACT_TICK,  10'd0,    1'b0, 1'b0, 1'b1, ST_IDLE},     // tick after reset
    '{ACT_NONE,  10'd1023, 1'b1, 1'b1, 1'b1, ST_IDLE},     // unused action, idle
    '{ACT_ABORT, 10'd0,    1'b0, 1'b0, 1'b1, ST_ABORTED},  // abort while idle
    '{ACT_START, 10'd1023, 1'b1, 1'b1, 1'b1, ST_REJECTED}, // all ones
    '{ACT_START, 10'd375,  1'b0, 1'b0, 1'b1, ST_REJECTED}, // multiple of 15, too big
    '{ACT_START, 10'd361,  1'b0, 1'b1, 1'b1, ST_REJECTED}, // not a multiple of 15
    '{ACT_START, 10'd0,    1'b0, 1'b0, 1'b1, ST_ACCEPTED}, // zero target
    '{ACT_TICK,  10'd0,    1'b0, 1'b0, 1'b0, ST_RUNNING},  // finishes at once
    '{ACT_TICK,  10'd512,  1'b1, 1'b1, 1'b1, ST_IDLE},
    '{ACT_START, 10'd15,   1'b1, 1'b1, 1'b1, ST_ACCEPTED}, // half step ccw
    '{ACT_TICK,  10'd0,    1'b0, 1'b0, 1'b0, ST_RUNNING},
    '{ACT_TICK,  10'd1023, 1'b1, 1'b1, 1'b0, ST_RUNNING},
    '{ACT_NONE,  10'd0,    1'b0, 1'b0, 1'b0, ST_RUNNING},  // unused action, running
    '{ACT_START, 10'd1000, 1'b0, 1'b0, 1'b0, ST_RUNNING},  // rejected while running
    '{ACT_START, 10'd30,   1'b0, 1'b1, 1'b1, ST_ACCEPTED}, // restart, half step cw
    '{ACT_TICK,  10'd0,    1'b0, 1'b0, 1'b0, ST_RUNNING},
    '{ACT_ABORT, 10'd0,    1'b1, 1'b1, 1'b1, ST_ABORTED},  // abort while running
    '{ACT_TICK,  10'd0,    1'b0, 1'b0, 1'b1, ST_IDLE},
    '{ACT_START, 10'd360,  1'b1, 1'b0, 1'b1, ST_ACCEPTED}, // largest target, full ccw
    '{ACT_TICK,  10'd0,    1'b0, 1'b0, 1'b0, ST_RUNNING},
    '{ACT_TICK,  10'd0,    1'b0, 1'b0, 1'b0, ST_RUNNING},
    '{ACT_START, 10'd45,   1'b0, 1'b0, 1'b1, ST_ACCEPTED}, // full step cw
    '{ACT_TICK,  10'd0,    1'b0, 1'b0, 1'b0, ST_RUNNING},
    '{ACT_ABORT, 10'd0,    1'b0, 1'b0, 1'b1, ST_ABORTED}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic [15:0] s_tdata;   // target_deg[9:0], direction[10], half_step[11]
  logic [1:0]  s_tuser;   // action[1:0]
  logic        m_tready;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [23:0] m_axis_tdata;  // coil[3:0], led_bar[11:4], position_deg[20:12],
                              // position_update[21]
  logic [2:0]  m_axis_tuser;  // status[2:0]
  logic        m_axis_tlast;

  stepper_angle_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // model state of the sequencer
  bit         seq_running;
  logic [11:0] seq_count;
  logic [8:0]  seq_pos;
  logic [8:0]  seq_target;
  logic        seq_ccw;
  logic        seq_half;
  logic [7:0]  seq_leds;

  phase_result_t pending_phases[$];
  phase_result_t mon_want;
  int  error_count;
  int  items_sent;
  int  idle_cycles;
  int  rx_hold;
  bit  quiet;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] fill_bar(int lvl, logic ccw);
    if (lvl == 0) return 8'h00;
    if (ccw) return 8'(8'hFF << (8 - lvl));
    return 8'((1 << lvl) - 1);
  endfunction

  task automatic push_single(input ssq_status_e st);
    phase_result_t r;
    r.coil   = COIL_OFF;
    r.leds   = seq_leds;
    r.pos    = seq_pos;
    r.upd    = 1'b0;
    r.status = st;
    r.last   = 1'b1;
    pending_phases.push_back(r);
  endtask

  // advance the model by one accepted item and queue the phases it causes
  task automatic predict_phases(input logic [1:0] act, input logic [9:0] deg,
                                input logic dir, input logic half);
    bit finished;
    bit upd;
    int nph;
    int lvl;
    phase_result_t r;
    finished = 0;
    upd = 0;
    if (act == ACT_START) begin
      if ((deg % 15 == 0) && (deg <= 10'd360)) begin
        seq_target  = deg[8:0];
        seq_ccw     = dir;
        seq_half    = half;
        seq_count   = '0;
        seq_pos     = '0;
        seq_leds    = '0;
        seq_running = 1;
        push_single(ST_ACCEPTED);
      end else begin
        push_single(ST_REJECTED);
      end
    end else if (act == ACT_ABORT) begin
      seq_running = 0;
      seq_count   = '0;
      seq_pos     = '0;
      seq_leds    = '0;
      push_single(ST_ABORTED);
    end else if (act == ACT_NONE || !seq_running) begin
      push_single(seq_running ? ST_RUNNING : ST_IDLE);
    end else begin
      // position check every 84 counts, with the snap at 2016
      if (seq_count % CHECK_PERIOD == 0) begin
        if (seq_count == SNAP_FROM) seq_count = SNAP_TO;
        if (seq_pos == seq_target) begin
          seq_pos  = '0;
          finished = 1;
        end else begin
          seq_pos = seq_pos + 9'd15;
          upd     = 1;
        end
      end
      if (seq_count % 256 == 0 && seq_count != 0) begin
        lvl = seq_count / 256;
        if (lvl <= 8) seq_leds = fill_bar(lvl, seq_ccw);
      end
      nph = seq_half ? 8 : 4;
      seq_count = seq_count + STEP_INC;
      if (finished) begin
        seq_running = 0;
        seq_count   = '0;
        seq_pos     = '0;
        seq_leds    = '0;
      end
      for (int k = 0; k < nph; k++) begin
        if (seq_half) r.coil = seq_ccw ? HALF_CCW[k] : HALF_CW[k];
        else          r.coil = seq_ccw ? FULL_CCW[k] : FULL_CW[k];
        r.leds   = seq_leds;
        r.pos    = seq_pos;
        r.upd    = upd;
        r.status = finished ? ST_DONE : ST_RUNNING;
        r.last   = (k == nph - 1);
        pending_phases.push_back(r);
      end
    end
  endtask

  // drive one item from a falling edge, hold it until taken, then predict
  task automatic offer_item(input logic [1:0] act, input logic [9:0] deg,
                            input logic dir, input logic half,
                            input bit typed, input ssq_status_e typed_status);
    int gap;
    phase_result_t r;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tdata  = {4'b0000, half, dir, deg};
    s_tuser  = act;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_phases(act, deg, dir, half);
    if (typed) begin
      // replace the model's answer with the one typed into the table
      void'(pending_phases.pop_back());
      r.coil   = COIL_OFF;
      r.leds   = '0;
      r.pos    = '0;
      r.upd    = 1'b0;
      r.status = typed_status;
      r.last   = 1'b1;
      pending_phases.push_back(r);
    end
    items_sent++;
  endtask

  function automatic logic [9:0] pick_target();
    if ($urandom_range(0, 5) == 0) return 10'(15 * $urandom_range(5, 8));
    return 10'(15 * $urandom_range(0, 4));
  endfunction

  task automatic random_tick();
    offer_item(ACT_TICK, 10'($urandom), 1'($urandom), 1'($urandom), 0, ST_IDLE);
  endtask

  task automatic random_noise();
    case ($urandom_range(0, 4))
      0: offer_item(ACT_NONE, 10'($urandom), 1'($urandom), 1'($urandom), 0, ST_IDLE);
      1: offer_item(ACT_START, 10'($urandom_range(0, 1023)), 1'($urandom),
                    1'($urandom), 0, ST_IDLE);
      2: offer_item(ACT_ABORT, 10'($urandom), 1'($urandom), 1'($urandom), 0, ST_IDLE);
      3: offer_item(ACT_START, pick_target(), 1'($urandom), 1'($urandom), 0, ST_IDLE);
      default: random_tick();
    endcase
  endtask

  // a valid start followed by ticks until the model reports the move over
  task automatic random_move(input logic [9:0] deg, input bit noisy);
    offer_item(ACT_START, deg, 1'($urandom), 1'($urandom), 0, ST_IDLE);
    while (seq_running) begin
      if (noisy && $urandom_range(0, 29) == 0) random_noise();
      else random_tick();
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // receiver: random stall bursts, none in the quiet tail
  always @(negedge clk_i) begin
    if (quiet) begin
      m_tready = 1'b1;
    end else if (rx_hold > 0) begin
      m_tready = 1'b0;
      rx_hold--;
    end else if ($urandom_range(0, 7) == 0) begin
      m_tready = 1'b0;
      rx_hold = $urandom_range(0, 18);
    end else begin
      m_tready = 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_tready) begin
      if (pending_phases.size() == 0) begin
        $error("result item with no expectation pending");
        error_count++;
      end else begin
        mon_want = pending_phases.pop_front();
        compare_field("coil", mon_want.coil, m_axis_tdata[3:0]);
        compare_field("led_bar", mon_want.leds, m_axis_tdata[11:4]);
        compare_field("position_deg", mon_want.pos, m_axis_tdata[20:12]);
        compare_field("position_update", mon_want.upd, m_axis_tdata[21]);
        compare_field("status", mon_want.status, m_axis_tuser);
        compare_field("last", mon_want.last, m_axis_tlast);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** stepper_angle_sequencer: FAILED **");
      $finish;
    end
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = ACT_TICK;
    m_tready    = 1'b0;
    rx_hold     = 0;
    quiet       = 0;
    error_count = 0;
    items_sent  = 0;
    idle_cycles = 0;
    seq_running = 0;
    seq_count   = '0;
    seq_pos     = '0;
    seq_target  = '0;
    seq_ccw     = 1'b0;
    seq_half    = 1'b0;
    seq_leds    = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_item(DIRECTED[i].act, DIRECTED[i].deg, DIRECTED[i].dir,
                 DIRECTED[i].half, DIRECTED[i].typed, DIRECTED[i].status);
    end

    // short moves with noise in and between them
    while (items_sent < 310) begin
      random_move(pick_target(), 1);
      if ($urandom_range(0, 2) == 0) random_noise();
    end
    // tail without idling on either side
    quiet = 1;
    repeat (2) random_move(10'(15 * $urandom_range(0, 2)), 1);
    random_noise();

    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (pending_phases.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** stepper_angle_sequencer: PASSED **");
    end else begin
      $display("** stepper_angle_sequencer: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ssq_pkg.sv
hdl/ssq_ctrl.sv
hdl/ssq_emit.sv
hdl/stepper_angle_sequencer.sv
hdl/ssq_checker.sv
bench/stepper_angle_sequencer_test.sv
